// ----- rtl/rotation_to_quaternion_and_euler_defines.svh -----
// Assertion macros for the rotation-to-quaternion block.
// Needs nothing else; taken in by the top level, which checks its own logic.
`ifndef ROTATION_TO_QUATERNION_AND_EULER_DEFINES_SVH
`define ROTATION_TO_QUATERNION_AND_EULER_DEFINES_SVH

// Same-cycle implication, quiet during reset
`define R2QE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("r2qe: same-cycle check failed");

// Next-cycle implication, quiet during reset
`define R2QE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("r2qe: next-cycle check failed");

`endif

// ----- rtl/r2qe_pkg.sv -----
// Types, constants and per-step functions of the rotation-to-quaternion pipeline.
// Depends on nothing; imported by the top level.
package r2qe_pkg;

	localparam int SQ_W    = 34;   // square root remainder width
	localparam int RT_W    = 17;   // square root result width
	localparam int CW      = 32;   // CORDIC x and y width
	localparam int ZW      = 20;   // CORDIC angle width, Q16 radians
	localparam int DV_W    = 30;   // dividend and remainder width
	localparam int MAG_W   = 17;   // magnitude of a numerator sum

	localparam int PI_Q16      = 205887;
	localparam int HALF_PI_Q16 = 102944;
	localparam int ONE_Q14     = 16384;
	localparam int ONE_Q28     = 268435456;

	// Stage map
	localparam int NS       = 36;
	localparam int SQ_LAST  = 17;
	localparam int CO_LAST  = 16;
	localparam int DP       = 18;
	localparam int DV_FIRST = 19;
	localparam int DV_LAST  = 34;
	localparam int OS       = 35;

	localparam logic signed [ZW-1:0] ATAN_TAB [16] = '{
		20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
		20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
		20'sd8, 20'sd4, 20'sd2
	};

	typedef enum logic [1:0] {COMP_X, COMP_Y, COMP_Z, COMP_W} comp_t;

	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [RT_W-1:0] root;
	} sqrt_t;

	// Diagonal component and the other three numerators, in x, y, z, w order
	typedef struct packed {
		comp_t                 diag;
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0]            neg;
	} qinfo_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} cord_t;

	typedef struct packed {
		logic [15:0]          sr;
		logic [2:0][DV_W-1:0] rem;
		logic [2:0][15:0]     quo;
	} div_t;

	// One bit of a floor square root
	function automatic sqrt_t sqrt_step(sqrt_t s, int b);
		sqrt_t             r;
		logic [SQ_W+1:0]   remx;
		logic [SQ_W+1:0]   trial;
		r = s;
		remx = (SQ_W+2)'(s.rem);
		trial = ((SQ_W+2)'(s.root) << (b + 1)) + ((SQ_W+2)'(1) << (2 * b));
		if (remx >= trial) begin
			r.rem  = SQ_W'(remx - trial);
			r.root = s.root | (RT_W'(1) << b);
		end
		return r;
	endfunction

	// Fold the left half-plane and scale into the CORDIC range
	function automatic cord_t cordic_pre(logic signed [17:0] y, logic signed [17:0] x);
		cord_t             c;
		logic signed [17:0] xa;
		logic signed [17:0] ya;
		xa = x;
		ya = y;
		c.z = '0;
		c.zero = (x == 18'sd0) && (y == 18'sd0);
		if (x < 18'sd0) begin
			c.z = (y >= 18'sd0) ? ZW'(PI_Q16) : ZW'(-PI_Q16);
			xa = -x;
			ya = -y;
		end
		c.x = CW'(xa) <<< 12;
		c.y = CW'(ya) <<< 12;
		return c;
	endfunction

	// One vectoring rotation
	function automatic cord_t cordic_iter(cord_t c, int i);
		cord_t                r;
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		r = c;
		xs = c.x >>> i;
		ys = c.y >>> i;
		if (!c.y[CW-1]) begin
			r.x = c.x + ys;
			r.y = c.y - xs;
			r.z = c.z + ATAN_TAB[4'(i)];
		end else begin
			r.x = c.x - ys;
			r.y = c.y + xs;
			r.z = c.z - ATAN_TAB[4'(i)];
		end
		return r;
	endfunction

	// One quotient bit of the three shared-divisor divisions
	function automatic div_t div_step(div_t d, int b);
		div_t        r;
		logic [30:0] sh;
		r = d;
		sh = 31'(d.sr) << b;
		for (int j = 0; j < 3; j++) begin
			if (31'(d.rem[j]) >= sh) begin
				r.rem[j] = DV_W'(31'(d.rem[j]) - sh);
				r.quo[j][4'(b)] = 1'b1;
			end
		end
		return r;
	endfunction

	// Apply sign and saturate a quotient magnitude
	function automatic logic signed [15:0] q_sat(logic [15:0] q, logic neg);
		logic signed [16:0] n;
		n = 17'sd0 - signed'({1'b0, q});
		if (!neg)
			return q[15] ? 16'sd32767 : signed'(q);
		else
			return (q > 16'd32768) ? -16'sd32768 : 16'(n);
	endfunction

	// Clamp, round to Q3.12 and negate
	function automatic logic signed [14:0] ang_out(logic signed [ZW-1:0] z, int lim);
		logic signed [ZW-1:0] c;
		logic signed [ZW-1:0] r;
		if (z > ZW'(lim))
			c = ZW'(lim);
		else if (z < ZW'(-lim))
			c = ZW'(-lim);
		else
			c = z;
		r = (c + ZW'(8)) >>> 4;
		return 15'(-r);
	endfunction

endpackage

// ----- rtl/rotation_to_quaternion_and_euler.sv -----
// Rotation matrix to quaternion and Euler angles, the whole pipeline.
// Depends on r2qe_pkg and rotation_to_quaternion_and_euler_defines.svh.
`include "rotation_to_quaternion_and_euler_defines.svh"

// Takes one 3x3 rotation (signed Q2.14) per request and returns the quaternion
// (Q2.14, four-branch trace method) and the negated pitch (Q2.12 radians), yaw and roll
// (Q3.12 radians), plus a gimbal-lock flag that forces yaw to zero. One matrix
// can enter every cycle while the pipeline has room; its result is presented
// after passing 36 register stages. The latency is set by the 17-stage floor
// square root followed by the 16-stage restoring divider that shares its root;
// the CORDIC angle units run beside them. A stall at the output holds only the
// stages that are full, so bubbles close up and the input keeps taking
// requests while a result waits.
module rotation_to_quaternion_and_euler (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                mat_valid,
	output logic                mat_ready,
	input  logic signed [15:0]  c0r0,
	input  logic signed [15:0]  c0r1,
	input  logic signed [15:0]  c0r2,
	input  logic signed [15:0]  c1r0,
	input  logic signed [15:0]  c1r1,
	input  logic signed [15:0]  c1r2,
	input  logic signed [15:0]  c2r0,
	input  logic signed [15:0]  c2r1,
	input  logic signed [15:0]  c2r2,
	output logic                res_valid,
	input  logic                res_ready,
	output logic signed [15:0]  quat_x,
	output logic signed [15:0]  quat_y,
	output logic signed [15:0]  quat_z,
	output logic signed [15:0]  quat_w,
	output logic signed [13:0]  neg_pitch,
	output logic signed [14:0]  neg_yaw,
	output logic signed [14:0]  neg_roll,
	output logic                gimbal_lock
);
	import r2qe_pkg::*;

	logic [NS-1:0] v_s;
	logic [NS-1:0] adv;

	qinfo_t             qi_s   [0:DV_LAST];
	logic               lock_s [0:DV_LAST];
	cord_t              cy_s   [0:DV_LAST];
	cord_t              cr_s   [0:DV_LAST];
	sqrt_t              sqq_s  [0:SQ_LAST];
	sqrt_t              sqp_s  [0:SQ_LAST];
	logic signed [15:0] p6_s   [0:SQ_LAST];
	div_t               dv_s   [DP:DV_LAST];
	cord_t              cp_s   [DP:DV_LAST];

	// Advance a stage when it is empty or the next one moves
	assign adv[OS] = !v_s[OS] || res_ready;
	for (genvar k = 0; k < OS; k++) begin : g_adv
		assign adv[k] = !v_s[k] || adv[k+1];
	end
	assign mat_ready = adv[0];
	assign res_valid = v_s[OS];

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int k = NS - 1; k > 0; k--) begin
				if (adv[k])
					v_s[k] <= v_s[k-1];
			end
			if (adv[0])
				v_s[0] <= mat_valid;
		end
	end

	// Front stage: pick the branch, form S and numerators, square the pitch term
	logic signed [17:0] tr;
	logic signed [18:0] s_w;
	logic signed [16:0] sp41, sp28, sp96, sm96, sm28, sm41;
	logic signed [16:0] d0, d1, d2;
	comp_t              diag_c;
	logic signed [15:0] p6c;
	logic signed [31:0] p6sq;
	logic [28:0]        xw;
	logic               lock_c;
	qinfo_t             qi_c;

	always_comb begin
		tr   = 18'(c0r0) + 18'(c1r1) + 18'(c2r2);
		sp41 = 17'(c1r0) + 17'(c0r1);
		sp28 = 17'(c0r2) + 17'(c2r0);
		sp96 = 17'(c2r1) + 17'(c1r2);
		sm96 = 17'(c2r1) - 17'(c1r2);
		sm28 = 17'(c0r2) - 17'(c2r0);
		sm41 = 17'(c1r0) - 17'(c0r1);
		priority if (!tr[17]) begin
			diag_c = COMP_W;
			s_w = 19'(tr) + 19'(ONE_Q14);
			d0 = sm96; d1 = sm28; d2 = sm41;
		end else if (c0r0 > c1r1 && c0r0 > c2r2) begin
			diag_c = COMP_X;
			s_w = 19'(ONE_Q14) + 19'(c0r0) - 19'(c1r1) - 19'(c2r2);
			d0 = sp41; d1 = sp28; d2 = sm96;
		end else if (c1r1 > c2r2) begin
			diag_c = COMP_Y;
			s_w = 19'(ONE_Q14) + 19'(c1r1) - 19'(c0r0) - 19'(c2r2);
			d0 = sp41; d1 = sp96; d2 = sm28;
		end else begin
			diag_c = COMP_Z;
			s_w = 19'(ONE_Q14) + 19'(c2r2) - 19'(c0r0) - 19'(c1r1);
			d0 = sp28; d1 = sp96; d2 = sm41;
		end
		qi_c.diag   = diag_c;
		qi_c.neg    = {d2[16], d1[16], d0[16]};
		qi_c.mag[0] = d0[16] ? MAG_W'(17'sd0 - d0) : MAG_W'(d0);
		qi_c.mag[1] = d1[16] ? MAG_W'(17'sd0 - d1) : MAG_W'(d1);
		qi_c.mag[2] = d2[16] ? MAG_W'(17'sd0 - d2) : MAG_W'(d2);

		if (c1r2 > 16'(ONE_Q14))
			p6c = 16'(ONE_Q14);
		else if (c1r2 < -16'(ONE_Q14))
			p6c = -16'(ONE_Q14);
		else
			p6c = c1r2;
		// 1 - m6^2 below 0.0001 happens only at a clamped unit argument
		lock_c = (c1r2 >= 16'(ONE_Q14)) || (c1r2 <= -16'(ONE_Q14));
		p6sq = p6c * p6c;
		xw = 29'(32'(ONE_Q28) - p6sq);
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			qi_s[0]       <= qi_c;
			lock_s[0]     <= lock_c;
			p6_s[0]       <= p6c;
			sqq_s[0].rem  <= SQ_W'({s_w[16:0], 14'b0});
			sqq_s[0].root <= '0;
			sqp_s[0].rem  <= SQ_W'({xw, 4'b0});
			sqp_s[0].root <= '0;
			cy_s[0]       <= cordic_pre(-18'(c0r2), 18'(c2r2));
			cr_s[0]       <= lock_c ? cordic_pre(18'(c0r1), 18'(c0r0))
			                        : cordic_pre(-18'(c1r0), 18'(c1r1));
		end
	end

	// Carry branch info and lock flag down to the output
	for (genvar k = 1; k <= DV_LAST; k++) begin : g_carry
		always_ff @(posedge clk) begin
			if (adv[k]) begin
				qi_s[k]   <= qi_s[k-1];
				lock_s[k] <= lock_s[k-1];
			end
		end
	end

	// Square roots: one result bit per stage, most significant first
	for (genvar k = 1; k <= SQ_LAST; k++) begin : g_sqrt
		always_ff @(posedge clk) begin
			if (adv[k]) begin
				sqq_s[k] <= sqrt_step(sqq_s[k-1], SQ_LAST - k);
				sqp_s[k] <= sqrt_step(sqp_s[k-1], SQ_LAST - k);
				p6_s[k]  <= p6_s[k-1];
			end
		end
	end

	// Yaw and roll CORDIC beside the square roots, then hold the angle
	for (genvar k = 1; k <= DV_LAST; k++) begin : g_yr
		if (k <= CO_LAST) begin : g_it
			always_ff @(posedge clk) begin
				if (adv[k]) begin
					cy_s[k] <= cordic_iter(cy_s[k-1], k - 1);
					cr_s[k] <= cordic_iter(cr_s[k-1], k - 1);
				end
			end
		end else begin : g_hold
			always_ff @(posedge clk) begin
				if (adv[k]) begin
					cy_s[k] <= cy_s[k-1];
					cr_s[k] <= cr_s[k-1];
				end
			end
		end
	end

	// Divider set-up: rounded dividends, and pitch CORDIC start
	div_t dv_c;
	always_comb begin
		dv_c.sr  = sqq_s[SQ_LAST].root[15:0];
		dv_c.quo = '0;
		for (int j = 0; j < 3; j++) begin
			dv_c.rem[j] = DV_W'({qi_s[SQ_LAST].mag[j], 13'b0}) + DV_W'(dv_c.sr >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[DP]) begin
			dv_s[DP] <= dv_c;
			cp_s[DP] <= cordic_pre(18'(p6_s[SQ_LAST]) <<< 2,
			                       signed'({1'b0, sqp_s[SQ_LAST].root}));
		end
	end

	// Division and pitch CORDIC, one step per stage
	for (genvar k = DV_FIRST; k <= DV_LAST; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv[k]) begin
				dv_s[k] <= div_step(dv_s[k-1], DV_LAST - k);
				cp_s[k] <= cordic_iter(cp_s[k-1], k - DV_FIRST);
			end
		end
	end

	// Output stage: saturate, place components, finish angles
	logic [15:0]        diagv;
	logic signed [15:0] o0, o1, o2;
	logic signed [15:0] qx_c, qy_c, qz_c, qw_c;
	logic signed [14:0] pq_c, yq_c, rq_c;
	cord_t              cyl, crl, cpl;

	always_comb begin
		diagv = 16'((17'(dv_s[DV_LAST].sr) + 17'd1) >> 1);
		o0 = q_sat(dv_s[DV_LAST].quo[0], qi_s[DV_LAST].neg[0]);
		o1 = q_sat(dv_s[DV_LAST].quo[1], qi_s[DV_LAST].neg[1]);
		o2 = q_sat(dv_s[DV_LAST].quo[2], qi_s[DV_LAST].neg[2]);
		unique case (qi_s[DV_LAST].diag)
			COMP_W: begin
				qx_c = o0; qy_c = o1; qz_c = o2; qw_c = signed'(diagv);
			end
			COMP_X: begin
				qx_c = signed'(diagv); qy_c = o0; qz_c = o1; qw_c = o2;
			end
			COMP_Y: begin
				qx_c = o0; qy_c = signed'(diagv); qz_c = o1; qw_c = o2;
			end
			COMP_Z: begin
				qx_c = o0; qy_c = o1; qz_c = signed'(diagv); qw_c = o2;
			end
			default: begin
				qx_c = o0; qy_c = o1; qz_c = o2; qw_c = signed'(diagv);
			end
		endcase
		cyl = cy_s[DV_LAST];
		crl = cr_s[DV_LAST];
		cpl = cp_s[DV_LAST];
		pq_c = ang_out(cpl.zero ? '0 : cpl.z, HALF_PI_Q16);
		rq_c = ang_out(crl.zero ? '0 : crl.z, PI_Q16);
		// Yaw is forced to zero in gimbal lock
		yq_c = (lock_s[DV_LAST] || cyl.zero) ? 15'sd0 : ang_out(cyl.z, PI_Q16);
	end

	always_ff @(posedge clk) begin
		if (adv[OS]) begin
			quat_x      <= qx_c;
			quat_y      <= qy_c;
			quat_z      <= qz_c;
			quat_w      <= qw_c;
			neg_pitch   <= 14'(pq_c);
			neg_yaw     <= yq_c;
			neg_roll    <= rq_c;
			gimbal_lock <= lock_s[DV_LAST];
		end
	end

	// Checks on the pipeline's own logic
	`R2QE_ASSERT_NXT(a_accept_lands, clk, arst_n, mat_valid && mat_ready, v_s[0])
	`R2QE_ASSERT_IMP(a_stall_full, clk, arst_n, !mat_ready, &v_s)
	`R2QE_ASSERT_IMP(a_root_floor, clk, arst_n, v_s[DP], dv_s[DP].sr >= 16'd16384)
	`R2QE_ASSERT_IMP(a_lock_yaw, clk, arst_n, res_valid && gimbal_lock, neg_yaw == 15'sd0)

endmodule

// ----- dv/tb_rotation_to_quaternion_and_euler.sv -----
// Testbench for the rotation-to-quaternion-and-Euler pipeline: predicts each pose
// in software and checks every result in order. Depends on the RTL top level only.
module tb_rotation_to_quaternion_and_euler;

	localparam longint PI_Q16      = 205887;
	localparam longint HALF_PI_Q16 = 102944;
	localparam longint GIMBAL_MIN  = 26844;

	typedef struct {
		logic signed [15:0] qx, qy, qz, qw;
		logic signed [13:0] pitch;
		logic signed [14:0] yaw, roll;
		logic               lock;
	} pose_t;

	localparam longint ATAN_STEP [16] = '{51472, 30386, 16055, 8150, 4091, 2047,
		1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic mat_valid = 1'b0;
	logic mat_ready;
	logic signed [15:0] c0r0 = '0, c0r1 = '0, c0r2 = '0, c1r0 = '0, c1r1 = '0;
	logic signed [15:0] c1r2 = '0, c2r0 = '0, c2r1 = '0, c2r2 = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
	logic signed [13:0] neg_pitch;
	logic signed [14:0] neg_yaw, neg_roll;
	logic gimbal_lock;

	pose_t pending_poses[$];
	int mismatches = 0;
	bit stall_on = 1'b1;

	rotation_to_quaternion_and_euler dut (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	// Floor square root
	function automatic longint root_floor(longint v);
		longint r, b;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > v) b = b >>> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else
				r = r >>> 1;
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint clip16(longint v);
		return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
	endfunction

	// Rounded division, halves away from zero
	function automatic longint round_quot(longint n, longint d);
		longint a, q;
		a = n < 0 ? -n : n;
		q = (a + d / 2) / d;
		return clip16(n < 0 ? -q : q);
	endfunction

	// Vectoring CORDIC atan2 in Q16 radians
	function automatic longint vec_angle(longint y, longint x);
		longint z, xs, ys;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			z = y >= 0 ? PI_Q16 : -PI_Q16;
			x = -x;
			y = -y;
		end
		x = x * 4096;
		y = y * 4096;
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z = z + ATAN_STEP[i];
			end else begin
				x = x - ys; y = y + xs; z = z - ATAN_STEP[i];
			end
		end
		return z > PI_Q16 ? PI_Q16 : (z < -PI_Q16 ? -PI_Q16 : z);
	endfunction

	function automatic longint neg_q12(longint a);
		return -((a + 8) >>> 4);
	endfunction

	// Expected pose for one matrix
	function automatic pose_t predict_pose(logic signed [15:0] e [9]);
		pose_t p;
		longint m0, m1, m2, m4, m5, m6, m8, m9, m10, t, sr, p6, xx, pit, yaw, rol;
		m0 = longint'(e[0]); m1 = longint'(e[1]); m2 = longint'(e[2]);
		m4 = longint'(e[3]); m5 = longint'(e[4]); m6 = longint'(e[5]);
		m8 = longint'(e[6]); m9 = longint'(e[7]); m10 = longint'(e[8]);
		t = m0 + m5 + m10;
		if (t >= 0) begin
			sr = root_floor((t + 16384) <<< 14);
			p.qw = 16'(clip16((sr + 1) >>> 1));
			p.qx = 16'(round_quot((m9 - m6) * 8192, sr));
			p.qy = 16'(round_quot((m2 - m8) * 8192, sr));
			p.qz = 16'(round_quot((m4 - m1) * 8192, sr));
		end else if (m0 > m5 && m0 > m10) begin
			sr = root_floor((16384 + m0 - m5 - m10) <<< 14);
			p.qx = 16'(clip16((sr + 1) >>> 1));
			p.qy = 16'(round_quot((m4 + m1) * 8192, sr));
			p.qz = 16'(round_quot((m2 + m8) * 8192, sr));
			p.qw = 16'(round_quot((m9 - m6) * 8192, sr));
		end else if (m5 > m10) begin
			sr = root_floor((16384 + m5 - m0 - m10) <<< 14);
			p.qy = 16'(clip16((sr + 1) >>> 1));
			p.qx = 16'(round_quot((m4 + m1) * 8192, sr));
			p.qz = 16'(round_quot((m9 + m6) * 8192, sr));
			p.qw = 16'(round_quot((m2 - m8) * 8192, sr));
		end else begin
			sr = root_floor((16384 + m10 - m0 - m5) <<< 14);
			p.qz = 16'(clip16((sr + 1) >>> 1));
			p.qx = 16'(round_quot((m2 + m8) * 8192, sr));
			p.qy = 16'(round_quot((m9 + m6) * 8192, sr));
			p.qw = 16'(round_quot((m4 - m1) * 8192, sr));
		end
		p6 = m6 > 16384 ? 16384 : (m6 < -16384 ? -16384 : m6);
		xx = (64'sd1 <<< 28) - p6 * p6;
		pit = vec_angle(p6 * 4, root_floor(xx <<< 4));
		pit = pit > HALF_PI_Q16 ? HALF_PI_Q16 : (pit < -HALF_PI_Q16 ? -HALF_PI_Q16 : pit);
		p.lock = xx < GIMBAL_MIN;
		if (!p.lock) begin
			yaw = vec_angle(-m2, m10);
			rol = vec_angle(-m4, m5);
		end else begin
			yaw = 0;
			rol = vec_angle(m1, m0);
		end
		p.pitch = 14'(neg_q12(pit));
		p.yaw = 15'(neg_q12(yaw));
		p.roll = 15'(neg_q12(rol));
		return p;
	endfunction

	// Send one matrix, holding it until accepted
	task automatic send_matrix(logic signed [15:0] e [9]);
		pending_poses.push_back(predict_pose(e));
		mat_valid <= 1'b1;
		{c0r0, c0r1, c0r2, c1r0, c1r1, c1r2, c2r0, c2r1, c2r2} <=
			{e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
		@(posedge clk);
		while (!mat_ready) @(posedge clk);
	endtask

	task automatic idle_gap(int n);
		mat_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rnd_elem();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'($urandom_range(0, 32768)) - 16'sd16384;
			default: return 16'($urandom);
		endcase
	endfunction

	// Plausible rotation: near-identity or axis permutations with small noise
	function automatic logic signed [15:0] near_val(int base);
		return 16'(base + int'($urandom_range(0, 400)) - 200);
	endfunction

	task automatic test_directed();
		logic signed [15:0] e [9];
		int vals [6] = '{0, 16384, -16384, 32767, -32768, 16383};
		// identity, axis flips
		e = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; send_matrix(e);
		e = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(e);
		e = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; send_matrix(e);
		e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_matrix(e);
		// diagonal ties
		e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(e);
		e = '{0, 0, 0, 0, -100, 0, 0, 0, -100}; send_matrix(e);
		// gimbal lock and asin saturation
		e = '{0, 16384, 0, 0, 0, 16384, 0, 16384, 0}; send_matrix(e);
		e = '{0, 0, 0, 0, 0, -16384, 0, 0, 0}; send_matrix(e);
		e = '{0, 0, 0, 0, 0, 32767, 0, 0, 0}; send_matrix(e);
		e = '{100, -200, 0, 0, 0, -32768, 0, 0, 0}; send_matrix(e);
		e = '{0, 0, 0, 0, 0, 16382, 0, 0, 0}; send_matrix(e);
		e = '{0, 0, 0, 0, 0, 16375, 0, 0, 0}; send_matrix(e);
		// zero over negative atan2 and all zero
		e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_matrix(e);
		e = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(e);
		// quaternion overflow
		e = '{-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767, -32768};
		send_matrix(e);
		e = '{32767, 32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768};
		send_matrix(e);
		for (int k = 0; k < 6; k++) begin
			foreach (e[i]) e[i] = 16'(vals[(k + i) % 6]);
			send_matrix(e);
		end
		idle_gap(1);
	endtask

	task automatic test_random(int count);
		logic signed [15:0] e [9];
		int sent, burst;
		int basis [3];
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 30);
			for (int b = 0; b < burst && sent < count; b++) begin
				if ($urandom_range(0, 3) == 0) begin
					foreach (e[i]) e[i] = rnd_elem();
				end else begin
					// signed permutation with noise
					basis[0] = $urandom_range(0, 2);
					basis[1] = (basis[0] + $urandom_range(1, 2)) % 3;
					basis[2] = 3 - basis[0] - basis[1];
					for (int c = 0; c < 3; c++)
						for (int r = 0; r < 3; r++)
							e[c * 3 + r] = near_val(r == basis[c] ?
								($urandom_range(0, 1) ? 16384 : -16384) : 0);
					if ($urandom_range(0, 4) == 0)
						e[5] = 16'($urandom_range(16350, 16384) * ($urandom_range(0, 1) ? 1 : -1));
				end
				send_matrix(e);
				sent++;
			end
			if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
		end
		idle_gap(1);
	endtask

	task automatic drain_results();
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Receiver stall pattern: alternate free-running and stalling stretches
	always @(posedge clk) begin
		if ($urandom_range(0, 99) == 0) stall_on <= ~stall_on;
		res_ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		pose_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_poses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result at %0t", $time);
			end else begin
				want = pending_poses.pop_front();
				if (want.qx !== quat_x || want.qy !== quat_y || want.qz !== quat_z ||
					want.qw !== quat_w || want.pitch !== neg_pitch ||
					want.yaw !== neg_yaw || want.roll !== neg_roll ||
					want.lock !== gimbal_lock) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp q=%0d,%0d,%0d,%0d a=%0d,%0d,%0d l=%0b",
							want.qx, want.qy, want.qz, want.qw, want.pitch, want.yaw,
							want.roll, want.lock,
							" got q=%0d,%0d,%0d,%0d a=%0d,%0d,%0d l=%0b",
							quat_x, quat_y, quat_z, quat_w,
							neg_pitch, neg_yaw, neg_roll, gimbal_lock);
				end
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(2000);
		drain_results();
		if (mismatches == 0 && pending_poses.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#4000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
